[src/cmyg_pkg.sv]
// Shared widths, register indexes and the mosaic phase table of the CMYG demosaic block.
`timescale 1ns / 1ps

package cmyg_pkg;

   localparam int PIX_W = 16;
   localparam int CNT_W = 32;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DEFAULT_MAX_WIDTH = 1024;

   localparam int MIN_WIDTH = 2;
   localparam int MIN_HEIGHT = 2;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_X_PHASE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_PHASE = 2'd3;

   // Reset values of the registers
   localparam logic [WIDTH_REG_W-1:0] RESET_WIDTH = 11'd508;
   localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 16'd489;
   localparam logic RESET_X_PHASE = 1'b1;
   localparam logic [1:0] RESET_Y_PHASE = 2'd2;

   // Window slots: 0 current, 1 left, 2 above, 3 above-left
   typedef logic [1:0] slot_type;

   // Role order inside an entry: G, Ye, C, M
   localparam int ROLE_G = 0;
   localparam int ROLE_YE = 1;
   localparam int ROLE_C = 2;
   localparam int ROLE_M = 3;

   localparam slot_type PHASE_MAP [8][4] = '{
      '{2'd3, 2'd1, 2'd0, 2'd2},
      '{2'd2, 2'd0, 2'd1, 2'd3},
      '{2'd0, 2'd3, 2'd2, 2'd1},
      '{2'd1, 2'd2, 2'd3, 2'd0},
      '{2'd2, 2'd1, 2'd0, 2'd3},
      '{2'd3, 2'd0, 2'd1, 2'd2},
      '{2'd1, 2'd3, 2'd2, 2'd0},
      '{2'd0, 2'd2, 2'd3, 2'd1}
   };

endpackage

[src/cmyg_if.sv]
// Stream interfaces for raw pixels in and RGB results out.
`timescale 1ns / 1ps

interface cmyg_req_if;
   logic                        valid;
   logic                        ready;
   logic [cmyg_pkg::PIX_W-1:0]  raw_pixel;
   logic                        frame_start;

   modport source (output valid, output raw_pixel, output frame_start, input ready);
   modport sink (input valid, input raw_pixel, input frame_start, output ready);
endinterface

interface cmyg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cmyg_pkg::PIX_W-1:0]  red;
   logic [cmyg_pkg::PIX_W-1:0]  green;
   logic [cmyg_pkg::PIX_W-1:0]  blue;
   logic [cmyg_pkg::PIX_W-1:0]  luma;
   logic [cmyg_pkg::CNT_W-1:0]  underflow_total;
   logic [cmyg_pkg::CNT_W-1:0]  overflow_total;
   logic                        frame_last;

   modport source (output valid, output red, output green, output blue, output luma,
                   output underflow_total, output overflow_total, output frame_last,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input luma,
                 input underflow_total, input overflow_total, input frame_last,
                 output ready);
endinterface

[src/cmyg_mosaic_to_rgb.sv]
// CMYG mosaic to RGB converter: line RAM, 2x2 window, color matrix, clamps and counters.
`timescale 1ns / 1ps

// A result is valid on rsp once its pixel has passed the stage 1, stage 2 and output registers.
// Throughput: one pixel per cycle while rsp does not stall; the single-port line RAM reads the pixel above and
//   writes the new pixel at the same column in the transfer cycle, which sets that rate.
// Pixels of row 0 and column 0 close no window and give no result.
// Reset (synchronous, active high) clears registers, position, window edges and clamp
//   counters; the line RAM is not cleared and is written by the first row of each frame.
module cmyg_mosaic_to_rgb #(
   parameter int MAX_WIDTH = cmyg_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cmyg_req_if.sink                             req_bus,
   cmyg_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [cmyg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cmyg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   // Compare width: holds both the width register and MAX_WIDTH itself
   localparam int WCMP_W = (COL_W + 1 > cmyg_pkg::WIDTH_REG_W) ? COL_W + 1
                                                                : cmyg_pkg::WIDTH_REG_W;
   localparam int PW = cmyg_pkg::PIX_W;
   localparam int HW = cmyg_pkg::HEIGHT_REG_W;
   localparam int CW = cmyg_pkg::CNT_W;

   // ---------------------------------------------------------------- registers
   logic [cmyg_pkg::WIDTH_REG_W-1:0] width_ff;
   logic [HW-1:0]                    height_ff;
   logic                             x_phase_ff;
   logic [1:0]                       y_phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= cmyg_pkg::RESET_WIDTH;
         height_ff  <= cmyg_pkg::RESET_HEIGHT;
         x_phase_ff <= cmyg_pkg::RESET_X_PHASE;
         y_phase_ff <= cmyg_pkg::RESET_Y_PHASE;
      end else if (csr_we) begin
         case (csr_index)
            cmyg_pkg::REG_IMAGE_WIDTH:  width_ff   <= csr_wdata[cmyg_pkg::WIDTH_REG_W-1:0];
            cmyg_pkg::REG_IMAGE_HEIGHT: height_ff  <= csr_wdata[HW-1:0];
            cmyg_pkg::REG_X_PHASE:      x_phase_ff <= csr_wdata[0];
            cmyg_pkg::REG_Y_PHASE:      y_phase_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   logic v1_ff, v2_ff, out_v_ff;
   logic prod2_ff;
   logic out_free, s2_go, s2_ready, s1_go, s1_ready, accept;

   assign out_free = !out_v_ff || rsp_bus.ready;
   assign s2_go    = v2_ff && (!prod2_ff || out_free);
   assign s2_ready = !v2_ff || s2_go;
   assign s1_go    = v1_ff && s2_ready;
   assign s1_ready = !v1_ff || s1_go;
   assign req_bus.ready = s1_ready;
   assign accept   = req_bus.valid && s1_ready;

   // ---------------------------------------------------------------- raster position
   logic [COL_W-1:0] col_ff;
   logic [HW-1:0]    row_ff;

   logic [WCMP_W-1:0] w_eff, cur_col_w, col_p1;
   logic [HW-1:0]     h_eff;
   logic [HW:0]       cur_row_x, row_p1;
   logic [COL_W-1:0]  cur_col, col_in;
   logic [HW-1:0]     cur_row, row_in;
   logic              cur_prod, cur_last;
   logic [2:0]        cur_mode;

   always_comb begin
      // Limit the width to 2..MAX_WIDTH and the height to at least 2
      w_eff = WCMP_W'(width_ff);
      if (w_eff < WCMP_W'(cmyg_pkg::MIN_WIDTH)) begin
         w_eff = WCMP_W'(cmyg_pkg::MIN_WIDTH);
      end
      if (w_eff > WCMP_W'(MAX_WIDTH)) begin
         w_eff = WCMP_W'(MAX_WIDTH);
      end
      h_eff = height_ff;
      if (h_eff < HW'(cmyg_pkg::MIN_HEIGHT)) begin
         h_eff = HW'(cmyg_pkg::MIN_HEIGHT);
      end

      // Frame start restarts at the origin; a shrunken size wraps the position
      cur_col_w = req_bus.frame_start ? '0 : WCMP_W'(col_ff);
      cur_row_x = req_bus.frame_start ? '0 : {1'b0, row_ff};
      if (cur_col_w >= w_eff) begin
         cur_col_w = '0;
         cur_row_x = cur_row_x + 1'b1;
      end
      if (cur_row_x >= {1'b0, h_eff}) begin
         cur_row_x = '0;
      end
      cur_col = cur_col_w[COL_W-1:0];
      cur_row = cur_row_x[HW-1:0];

      cur_prod = (cur_row != '0) && (cur_col != '0);
      cur_last = (cur_row_x == {1'b0, h_eff} - 1'b1) && (cur_col_w == w_eff - 1'b1);
      cur_mode = {cur_row[1:0] + y_phase_ff, cur_col[0] ^ x_phase_ff};

      // Advance to the next raster position
      col_p1 = cur_col_w + 1'b1;
      row_p1 = cur_row_x;
      if (col_p1 >= w_eff) begin
         col_p1 = '0;
         row_p1 = cur_row_x + 1'b1;
         if (row_p1 >= {1'b0, h_eff}) begin
            row_p1 = '0;
         end
      end
      col_in = col_p1[COL_W-1:0];
      row_in = row_p1[HW-1:0];
   end

   // ---------------------------------------------------------------- line RAM
   // Read-before-write at the current column: fetch the pixel above, store this one
   logic [PW-1:0] line_ram [MAX_WIDTH];
   logic [PW-1:0] above_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         above_ff         <= line_ram[cur_col];
         line_ram[cur_col] <= req_bus.raw_pixel;
      end
   end

   // ---------------------------------------------------------------- stage 1 capture
   logic [PW-1:0] left_ff, ul_ff;
   logic [PW-1:0] pix1_ff, left1_ff;
   logic [2:0]    mode1_ff;
   logic          prod1_ff, last1_ff, clr1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
         ul_ff   <= '0;
         v1_ff   <= 1'b0;
      end else begin
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            left_ff <= req_bus.raw_pixel;
         end
         // Above-left of the next window is the above pixel of this one
         if (s1_go) begin
            ul_ff <= above_ff;
         end
         if (accept) begin
            v1_ff <= 1'b1;
         end else if (s1_go) begin
            v1_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff  <= req_bus.raw_pixel;
         left1_ff <= left_ff;
         mode1_ff <= cur_mode;
         prod1_ff <= cur_prod;
         last1_ff <= cur_last;
         clr1_ff  <= req_bus.frame_start;
      end
   end

   // ---------------------------------------------------------------- stage 1 color matrix
   logic [PW-1:0]          win [4];
   logic [PW-1:0]          g_s, ye_s, c_s, m_s;
   logic [PW:0]            gc_sum, mye_sum, mc_sum, gye_sum;
   logic [PW+1:0]          all_sum;
   logic [PW:0]            y_val;
   logic signed [PW+2:0]   red_val, blue_val;

   always_comb begin
      win[0] = pix1_ff;
      win[1] = left1_ff;
      win[2] = above_ff;
      win[3] = ul_ff;
      g_s  = win[cmyg_pkg::PHASE_MAP[mode1_ff][cmyg_pkg::ROLE_G]];
      ye_s = win[cmyg_pkg::PHASE_MAP[mode1_ff][cmyg_pkg::ROLE_YE]];
      c_s  = win[cmyg_pkg::PHASE_MAP[mode1_ff][cmyg_pkg::ROLE_C]];
      m_s  = win[cmyg_pkg::PHASE_MAP[mode1_ff][cmyg_pkg::ROLE_M]];

      gc_sum  = {1'b0, g_s} + {1'b0, c_s};
      mye_sum = {1'b0, m_s} + {1'b0, ye_s};
      mc_sum  = {1'b0, m_s} + {1'b0, c_s};
      gye_sum = {1'b0, g_s} + {1'b0, ye_s};
      all_sum = {1'b0, gc_sum} + {1'b0, mye_sum};
      y_val   = all_sum[PW+1:1];

      red_val  = $signed({2'b00, mye_sum}) - $signed({2'b00, gc_sum})
               + $signed({2'b00, y_val});
      blue_val = $signed({2'b00, mc_sum}) - $signed({2'b00, gye_sum})
               + $signed({2'b00, y_val});
   end

   // ---------------------------------------------------------------- stage 2 registers
   logic signed [PW+2:0] red2_ff, blue2_ff;
   logic [PW:0]          y2_ff;
   logic [PW-1:0]        g2_ff;
   logic                 last2_ff, clr2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (s1_go) begin
         v2_ff <= 1'b1;
      end else if (s2_go) begin
         v2_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         red2_ff  <= red_val;
         blue2_ff <= blue_val;
         y2_ff    <= y_val;
         g2_ff    <= g_s;
         prod2_ff <= prod1_ff;
         last2_ff <= last1_ff;
         clr2_ff  <= clr1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 2 clamp and count
   logic          red_lo, red_hi, blue_lo, blue_hi, y_hi;
   logic [1:0]    lo_n, hi_n;
   logic [CW-1:0] lo_cnt_ff, hi_cnt_ff, lo_base, hi_base, lo_cnt_in, hi_cnt_in;
   logic [CW:0]   lo_sum, hi_sum;
   logic [PW-1:0] red_cl, blue_cl, y_cl;

   always_comb begin
      // Green is a raw sample and never clamps; luma is never negative
      red_lo  = red2_ff[PW+2];
      red_hi  = !red_lo && (red2_ff[PW+1:PW] != 2'b00);
      blue_lo = blue2_ff[PW+2];
      blue_hi = !blue_lo && (blue2_ff[PW+1:PW] != 2'b00);
      y_hi    = y2_ff[PW];

      red_cl  = red_lo ? '0 : (red_hi ? '1 : red2_ff[PW-1:0]);
      blue_cl = blue_lo ? '0 : (blue_hi ? '1 : blue2_ff[PW-1:0]);
      y_cl    = y_hi ? '1 : y2_ff[PW-1:0];

      lo_n = prod2_ff ? (2'(red_lo) + 2'(blue_lo)) : 2'd0;
      hi_n = prod2_ff ? (2'(red_hi) + 2'(blue_hi) + 2'(y_hi)) : 2'd0;

      // Frame start clears the counts before its own window is tallied
      lo_base = clr2_ff ? '0 : lo_cnt_ff;
      hi_base = clr2_ff ? '0 : hi_cnt_ff;
      lo_sum  = {1'b0, lo_base} + (CW + 1)'(lo_n);
      hi_sum  = {1'b0, hi_base} + (CW + 1)'(hi_n);
      lo_cnt_in = lo_sum[CW] ? '1 : lo_sum[CW-1:0];
      hi_cnt_in = hi_sum[CW] ? '1 : hi_sum[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_cnt_ff <= '0;
         hi_cnt_ff <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         if (s2_go) begin
            lo_cnt_ff <= lo_cnt_in;
            hi_cnt_ff <= hi_cnt_in;
         end
         // Hold the result until transfer; drop items that close no window
         if (s2_go && prod2_ff) begin
            out_v_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- output register
   logic [PW-1:0] red_out_ff, green_out_ff, blue_out_ff, luma_out_ff;
   logic [CW-1:0] under_out_ff, over_out_ff;
   logic          last_out_ff;

   always_ff @(posedge clock) begin
      if (s2_go && prod2_ff) begin
         red_out_ff   <= red_cl;
         green_out_ff <= g2_ff;
         blue_out_ff  <= blue_cl;
         luma_out_ff  <= y_cl;
         under_out_ff <= lo_cnt_in;
         over_out_ff  <= hi_cnt_in;
         last_out_ff  <= last2_ff;
      end
   end

   assign rsp_bus.valid           = out_v_ff;
   assign rsp_bus.red             = red_out_ff;
   assign rsp_bus.green           = green_out_ff;
   assign rsp_bus.blue            = blue_out_ff;
   assign rsp_bus.luma            = luma_out_ff;
   assign rsp_bus.underflow_total = under_out_ff;
   assign rsp_bus.overflow_total  = over_out_ff;
   assign rsp_bus.frame_last      = last_out_ff;

endmodule
